[hdl/c3lr_pkg.sv]
// Shared types and constants for the 3x3 convolution / leaky ReLU core.
`default_nettype none
package c3lr_pkg;

    localparam int DEF_MAX_OUT_COLUMNS = 64;
    localparam int DEF_MAX_OUT_ROWS    = 16;
    localparam int DEF_SAMPLE_BITS     = 16;

    localparam int COEF_W  = 16;
    localparam int SUM_W   = 48;
    localparam int FRAC_W  = 12;
    localparam int LEAK_Q  = 6554;     // 0.1 in Q0.16
    localparam int DIM_W   = 10;       // holds any size up to 258 and any 7-bit write
    localparam int CIDX_W  = 3;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_KERNEL_TOP = 3'd0;
    localparam logic [CIDX_W-1:0] REG_KERNEL_MID = 3'd1;
    localparam logic [CIDX_W-1:0] REG_KERNEL_BOT = 3'd2;
    localparam logic [CIDX_W-1:0] REG_BIAS       = 3'd3;
    localparam logic [CIDX_W-1:0] REG_IN_COLS    = 3'd4;
    localparam logic [CIDX_W-1:0] REG_IN_ROWS    = 3'd5;

    localparam logic [6:0] RST_IN_COLS = 7'd66;
    localparam logic [4:0] RST_IN_ROWS = 5'd18;

    typedef struct packed {
        logic [3*COEF_W-1:0] kernel_top;
        logic [3*COEF_W-1:0] kernel_mid;
        logic [3*COEF_W-1:0] kernel_bot;
        logic signed [15:0]  bias;
        logic [6:0]          input_columns;
        logic [4:0]          input_rows;
    } cfg_t;

endpackage
`default_nettype wire

[hdl/c3lr_queue.sv]
// Two-entry job queue between the window front end and the MAC back end.
`default_nettype none
module c3lr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && push_ready)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && push_ready)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && pop_valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push && push_ready, pop && pop_valid})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/c3lr_front.sv]
// Front end: raster position, line store, 3x3 window, job build.
`default_nettype none
module c3lr_front #(
    parameter int MAX_OUT_COLUMNS = 64,
    parameter int MAX_OUT_ROWS    = 16,
    parameter int SAMPLE_BITS     = 16,
    parameter int JOB_W           = 160
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire c3lr_pkg::cfg_t               cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic                         first_plane,
    input  wire logic                         last_plane,
    output logic                              job_push,
    output logic [JOB_W-1:0]                  job_data,
    input  wire logic                         job_ready
);
    import c3lr_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int ROW_LEN = MAX_OUT_COLUMNS + 2;
    localparam int LS_AW   = $clog2(ROW_LEN);
    localparam int OC_W    = $clog2(MAX_OUT_COLUMNS);
    localparam int OR_W    = $clog2(MAX_OUT_ROWS);
    localparam logic [DIM_W-1:0] COL_MAX = DIM_W'(ROW_LEN);
    localparam logic [DIM_W-1:0] ROW_MAX = DIM_W'(MAX_OUT_ROWS + 2);
    localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);
    localparam logic [DIM_W-1:0] TWO     = DIM_W'(2);

    typedef enum logic {F_IDLE, F_WORK} fstate_t;

    fstate_t state_reg;
    logic [2*SB-1:0] line_mem [ROW_LEN];   // low half: row r-2, high half: row r-1
    logic [2*SB-1:0] ls_rd_reg;
    logic [SB-1:0]   win_reg [6];
    logic [SB-1:0]   sample_reg;
    logic            first_reg, last_reg;
    logic [DIM_W-1:0] col_cnt_reg, row_cnt_reg, c_reg, r_reg;

    logic [DIM_W-1:0] cin, rin, cols, rows, c_now, r_now;
    logic [SB-1:0]    col3 [3];
    logic             pos_ok, advance, at_end;
    logic [OC_W-1:0]  oc;
    logic [OR_W-1:0]  orow;

    always_comb
    begin
        cin   = DIM_W'(cfg.input_columns);
        rin   = DIM_W'(cfg.input_rows);
        cols  = (cin < DIM_MIN) ? DIM_MIN : ((cin > COL_MAX) ? COL_MAX : cin);
        rows  = (rin < DIM_MIN) ? DIM_MIN : ((rin > ROW_MAX) ? ROW_MAX : rin);
        c_now = (col_cnt_reg < cols) ? col_cnt_reg : cols - 1'b1;
        r_now = (row_cnt_reg < rows) ? row_cnt_reg : rows - 1'b1;
        col3[0] = ls_rd_reg[SB-1:0];
        col3[1] = ls_rd_reg[2*SB-1:SB];
        col3[2] = sample_reg;
        pos_ok  = (c_reg >= TWO) && (r_reg >= TWO);
        advance = (state_reg == F_WORK) && (!pos_ok || job_ready);
        at_end  = (c_reg == cols - 1'b1) && (r_reg == rows - 1'b1);
        oc      = OC_W'(c_reg - TWO);
        orow    = OR_W'(r_reg - TWO);
        job_data = {at_end, last_reg, first_reg, orow, oc,
                    col3[2], win_reg[5], win_reg[4],
                    col3[1], win_reg[3], win_reg[2],
                    col3[0], win_reg[1], win_reg[0]};
    end

    assign in_ready = (state_reg == F_IDLE);
    assign job_push = advance && pos_ok;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ls_rd_reg  <= line_mem[c_now[LS_AW-1:0]];
            sample_reg <= sample;
            first_reg  <= first_plane;
            last_reg   <= last_plane;
            c_reg      <= c_now;
            r_reg      <= r_now;
        end
        if (advance)
        begin
            line_mem[c_reg[LS_AW-1:0]] <= {sample_reg, col3[1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= F_WORK;
                    end
                end
                F_WORK:
                begin
                    if (advance)
                    begin
                        state_reg <= F_IDLE;
                        for (int i = 0; i < 3; i++)
                        begin
                            win_reg[2*i]   <= win_reg[2*i+1];
                            win_reg[2*i+1] <= col3[i];
                        end
                        if (c_reg >= cols - 1'b1)
                        begin
                            col_cnt_reg <= '0;
                            row_cnt_reg <= (r_reg >= rows - 1'b1) ? '0 : r_reg + 1'b1;
                        end
                        else
                        begin
                            col_cnt_reg <= c_reg + 1'b1;
                            row_cnt_reg <= r_reg;
                        end
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/c3lr_back.sv]
// Back end: serial 9-tap MAC, partial-sum memory, leaky ReLU, output register.
`default_nettype none
module c3lr_back #(
    parameter int MAX_OUT_COLUMNS = 64,
    parameter int MAX_OUT_ROWS    = 16,
    parameter int SAMPLE_BITS     = 16,
    parameter int JOB_W           = 160
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire c3lr_pkg::cfg_t        cfg,
    input  wire logic                  job_valid,
    input  wire logic [JOB_W-1:0]      job_data,
    output logic                       job_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [SAMPLE_BITS-1:0]     activated_value,
    output logic [$clog2(MAX_OUT_COLUMNS)-1:0] out_column,
    output logic [$clog2(MAX_OUT_ROWS)-1:0]    out_row,
    output logic                       last
);
    import c3lr_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int OC_W   = $clog2(MAX_OUT_COLUMNS);
    localparam int OR_W   = $clog2(MAX_OUT_ROWS);
    localparam int DEPTH  = MAX_OUT_COLUMNS * MAX_OUT_ROWS;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int PROD_W = SB + COEF_W;
    localparam int ACC_W  = PROD_W + 4;
    localparam int MUL_W  = SUM_W + 14;
    localparam int POS_W  = SUM_W + 1 - FRAC_W;
    localparam int NEG_W  = MUL_W - 28;
    localparam int X_OFF  = 9 * SB;
    localparam logic signed [POS_W-1:0] VMAX = POS_W'((64'sd1 <<< (SB - 1)) - 1);
    localparam logic signed [POS_W-1:0] VMIN = -VMAX - 1'b1;
    localparam logic [3:0] LAST_TAP = 4'd9;

    typedef enum logic [2:0] {B_IDLE, B_MAC, B_SUM, B_ACT, B_RND} bstate_t;

    bstate_t state_reg;
    logic signed [SUM_W-1:0] psum_mem [DEPTH];
    logic signed [SUM_W-1:0] psum_rd_reg, sum_reg;
    logic [JOB_W-1:0]        job_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [3:0]              tap_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [MUL_W-1:0]  mul_reg;

    logic signed [SB-1:0]     x_sel;
    logic signed [COEF_W-1:0] k_sel;
    logic [OC_W-1:0]          q_oc;
    logic [OR_W-1:0]          q_or;
    logic [IDX_W-1:0]         q_idx;
    logic signed [SUM_W:0]    base, sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic signed [SUM_W:0]    pos_t;
    logic signed [MUL_W-1:0]  neg_t;
    logic signed [POS_W-1:0]  v_raw, v_sat;
    logic                     j_first, j_last, j_end;

    always_comb
    begin
        q_oc  = job_data[X_OFF +: OC_W];
        q_or  = job_data[X_OFF + OC_W +: OR_W];
        q_idx = IDX_W'(q_or * MAX_OUT_COLUMNS) + IDX_W'(q_oc);
        j_first = job_reg[X_OFF + OC_W + OR_W];
        j_last  = job_reg[X_OFF + OC_W + OR_W + 1];
        j_end   = job_reg[X_OFF + OC_W + OR_W + 2];

        x_sel = job_reg[0 +: SB];
        k_sel = cfg.kernel_top[0 +: COEF_W];
        case (tap_reg)
            4'd0: begin x_sel = job_reg[0*SB +: SB]; k_sel = cfg.kernel_top[0  +: COEF_W]; end
            4'd1: begin x_sel = job_reg[1*SB +: SB]; k_sel = cfg.kernel_top[16 +: COEF_W]; end
            4'd2: begin x_sel = job_reg[2*SB +: SB]; k_sel = cfg.kernel_top[32 +: COEF_W]; end
            4'd3: begin x_sel = job_reg[3*SB +: SB]; k_sel = cfg.kernel_mid[0  +: COEF_W]; end
            4'd4: begin x_sel = job_reg[4*SB +: SB]; k_sel = cfg.kernel_mid[16 +: COEF_W]; end
            4'd5: begin x_sel = job_reg[5*SB +: SB]; k_sel = cfg.kernel_mid[32 +: COEF_W]; end
            4'd6: begin x_sel = job_reg[6*SB +: SB]; k_sel = cfg.kernel_bot[0  +: COEF_W]; end
            4'd7: begin x_sel = job_reg[7*SB +: SB]; k_sel = cfg.kernel_bot[16 +: COEF_W]; end
            4'd8: begin x_sel = job_reg[8*SB +: SB]; k_sel = cfg.kernel_bot[32 +: COEF_W]; end
            default: begin x_sel = '0; k_sel = '0; end
        endcase

        // bias enters as bias * 2^12
        base = j_first ? ((SUM_W + 1)'(cfg.bias) <<< FRAC_W) : (SUM_W + 1)'(psum_rd_reg);
        sum_wide = base + (SUM_W + 1)'(acc_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end

        pos_t = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(1 << (FRAC_W - 1));
        neg_t = mul_reg + MUL_W'(64'sd1 <<< 27);
        v_raw = sum_reg[SUM_W-1] ? POS_W'($signed(neg_t[MUL_W-1:28])) : pos_t[SUM_W:FRAC_W];
        v_sat = (v_raw > VMAX) ? VMAX : ((v_raw < VMIN) ? VMIN : v_raw);
    end

    assign job_pop = (state_reg == B_IDLE);

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && job_valid)
        begin
            job_reg     <= job_data;
            idx_reg     <= q_idx;
            psum_rd_reg <= psum_mem[q_idx];
        end
        if (state_reg == B_MAC)
        begin
            prod_reg <= x_sel * k_sel;
        end
        if (state_reg == B_SUM)
        begin
            psum_mem[idx_reg] <= sum_sat;
            sum_reg           <= sum_sat;
        end
        if (state_reg == B_ACT)
        begin
            mul_reg <= MUL_W'(sum_reg) * MUL_W'(LEAK_Q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            tap_reg         <= '0;
            acc_reg         <= '0;
            out_valid       <= 1'b0;
            activated_value <= '0;
            out_column      <= '0;
            out_row         <= '0;
            last            <= 1'b0;
        end
        else
        begin
            // B_RND reloads the output register itself
            if (out_valid && out_ready && state_reg != B_RND)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        tap_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= B_MAC;
                    end
                end
                B_MAC:
                begin
                    if (tap_reg != '0)
                    begin
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    end
                    tap_reg <= tap_reg + 1'b1;
                    if (tap_reg == LAST_TAP)
                    begin
                        state_reg <= B_SUM;
                    end
                end
                B_SUM:
                begin
                    state_reg <= j_last ? B_ACT : B_IDLE;
                end
                B_ACT:
                begin
                    state_reg <= B_RND;
                end
                B_RND:
                begin
                    if (!out_valid || out_ready)
                    begin
                        out_valid       <= 1'b1;
                        activated_value <= v_sat[SB-1:0];
                        out_column      <= job_reg[X_OFF +: OC_W];
                        out_row         <= job_reg[X_OFF + OC_W +: OR_W];
                        last            <= j_end;
                        state_reg       <= B_IDLE;
                    end
                    else
                    begin
                        out_valid <= 1'b1;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/conv3x3_accumulate_leaky_relu_core.sv]
// Top level: config registers, front end, job queue and back end.
//
// Usage: load the three kernel rows, bias and sizes on the cfg port while the
// core is idle, then stream one input plane in raster order on the s_ channel
// (one word per pixel, tuser[0] = first plane, tuser[1] = last plane).
// Windows with row and column both >= 2 each become a job; the job adds the
// 3x3 dot product into a partial-sum memory (bias starts it on a first plane).
// On a last plane each job also yields one word on the m_ channel: leaky ReLU
// result rounded to Q3.12 with saturation, its output column and row, and
// tlast on the final position of the plane.
// The front end reads the line store as it takes a word and writes it back
// before the next; a window word waits while the job queue is full. The
// back end runs one shared multiplier over the nine taps, adds activation
// steps on a last plane, then takes a new job; borders use only the front end.
// A two-entry queue decouples the halves; when m_tready is low the result
// waits in the output register while the front end keeps filling the queue.
// Reset clears control state, window registers and counters and sets the
// sizes to 66 x 18; line store and partial sums are undefined until written.
`default_nettype none
module conv3x3_accumulate_leaky_relu_core #(
    parameter int MAX_OUT_COLUMNS = c3lr_pkg::DEF_MAX_OUT_COLUMNS,
    parameter int MAX_OUT_ROWS    = c3lr_pkg::DEF_MAX_OUT_ROWS,
    parameter int SAMPLE_BITS     = c3lr_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [c3lr_pkg::CIDX_W-1:0]     cfg_index,
    input  wire logic [3*c3lr_pkg::COEF_W-1:0]   cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // tdata: sample
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: first_plane, last_plane
    input  wire logic [1:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // tdata: activated_value, out_column, out_row
    output logic [((SAMPLE_BITS+$clog2(MAX_OUT_COLUMNS)+$clog2(MAX_OUT_ROWS)+7)/8)*8-1:0]
                                                 m_tdata,
    output logic                                 m_tlast
);
    import c3lr_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int OC_W  = $clog2(MAX_OUT_COLUMNS);
    localparam int OR_W  = $clog2(MAX_OUT_ROWS);
    localparam int OUT_W = ((SB + OC_W + OR_W + 7) / 8) * 8;
    localparam int JOB_W = 9 * SB + OC_W + OR_W + 3;

    cfg_t cfg_reg;

    logic             job_push, job_ready, job_valid, job_pop;
    logic [JOB_W-1:0] job_in, job_out;
    logic [SB-1:0]    act_value;
    logic [OC_W-1:0]  out_col;
    logic [OR_W-1:0]  out_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kernel_top    <= '0;
            cfg_reg.kernel_mid    <= '0;
            cfg_reg.kernel_bot    <= '0;
            cfg_reg.bias          <= '0;
            cfg_reg.input_columns <= RST_IN_COLS;
            cfg_reg.input_rows    <= RST_IN_ROWS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KERNEL_TOP: cfg_reg.kernel_top    <= cfg_data;
                REG_KERNEL_MID: cfg_reg.kernel_mid    <= cfg_data;
                REG_KERNEL_BOT: cfg_reg.kernel_bot    <= cfg_data;
                REG_BIAS:       cfg_reg.bias          <= cfg_data[15:0];
                REG_IN_COLS:    cfg_reg.input_columns <= cfg_data[6:0];
                REG_IN_ROWS:    cfg_reg.input_rows    <= cfg_data[4:0];
                default:        cfg_reg               <= cfg_reg;  // unmapped index
            endcase
        end
    end

    c3lr_front #(
        .MAX_OUT_COLUMNS(MAX_OUT_COLUMNS),
        .MAX_OUT_ROWS   (MAX_OUT_ROWS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .JOB_W          (JOB_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .sample     (s_tdata[SB-1:0]),
        .first_plane(s_tuser[0]),
        .last_plane (s_tuser[1]),
        .job_push   (job_push),
        .job_data   (job_in),
        .job_ready  (job_ready)
    );

    c3lr_queue #(
        .WIDTH(JOB_W),
        .DEPTH(2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .push_ready(job_ready),
        .pop       (job_pop),
        .pop_valid (job_valid),
        .pop_data  (job_out)
    );

    c3lr_back #(
        .MAX_OUT_COLUMNS(MAX_OUT_COLUMNS),
        .MAX_OUT_ROWS   (MAX_OUT_ROWS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .JOB_W          (JOB_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .job_valid      (job_valid),
        .job_data       (job_out),
        .job_pop        (job_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .activated_value(act_value),
        .out_column     (out_col),
        .out_row        (out_row),
        .last           (m_tlast)
    );

    assign m_tdata = OUT_W'({out_row, out_col, act_value});
endmodule
`default_nettype wire

[hdl/c3lr_checker.sv]
// Port-level checker for the convolution core, bound to the top level.
`default_nettype none
module c3lr_checker #(
    parameter int OUT_W = 32
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic             m_tlast
);
    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // front end writes the line store before it takes the next word
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // an offered result carries known data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast}))
        else $error("result word has unknown bits");

    // output register is empty right after reset
    assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");
endmodule

bind conv3x3_accumulate_leaky_relu_core c3lr_checker #(
    .OUT_W($bits(m_tdata))
) u_c3lr_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the 3x3 convolution / leaky ReLU core.
`timescale 1ns / 1ps
module tb_top;
    import c3lr_pkg::*;

    localparam int ROW_LEN   = DEF_MAX_OUT_COLUMNS + 2;
    localparam int WDOG_MAX  = 4000;
    localparam int HOLD_LEN  = 400;
    localparam int SETTLE    = 100;  // > front end + queue + back end drain time
    localparam longint SUM_HI = (64'sd1 <<< 47) - 1;
    localparam longint SUM_LO = -(64'sd1 <<< 47);

    typedef struct packed {
        logic [15:0] smp;
        logic        first_pl;
        logic        last_pl;
    } pix_t;

    typedef struct packed {
        logic [15:0] act;
        logic [5:0]  ocol;
        logic [3:0]  orow;
        logic        olast;
    } act_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [47:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // sample
    logic [1:0]  s_tuser;     // first_plane, last_plane
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // activated_value, out_column, out_row, zero fill
    logic        m_tlast;

    conv3x3_accumulate_leaky_relu_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stimulus and expectation stores
    pix_t pix_q[$];
    act_t act_q[$];
    int   n_err;
    int   n_words;
    int   n_results;

    // predictor copy of the configuration
    logic [47:0]        kern_sh[3];
    logic signed [15:0] bias_sh;
    logic [6:0]         cols_sh;
    logic [4:0]         rows_sh;

    // predictor copy of the datapath state
    logic signed [15:0] line_sh[2*ROW_LEN];
    logic signed [15:0] win_sh[6];
    longint             psum_sh[1024];
    int                 col_pos;
    int                 row_pos;

    // one pixel through the layer model; queues the activation if one is due
    task automatic conv_pixel(input pix_t p);
        int     ncol;
        int     nrow;
        int     c;
        int     r;
        int     idx;
        longint dot;
        longint acc;
        longint v;
        logic signed [15:0] col3[3];
        act_t   a;
        ncol = (cols_sh < 3) ? 3 : (cols_sh > ROW_LEN) ? ROW_LEN : cols_sh;
        nrow = (rows_sh < 3) ? 3 : (rows_sh > DEF_MAX_OUT_ROWS + 2) ?
               DEF_MAX_OUT_ROWS + 2 : rows_sh;
        c = (col_pos < ncol) ? col_pos : ncol - 1;
        r = (row_pos < nrow) ? row_pos : nrow - 1;
        col3[0] = line_sh[c];
        col3[1] = line_sh[ROW_LEN + c];
        col3[2] = $signed(p.smp);
        line_sh[c] = col3[1];
        line_sh[ROW_LEN + c] = col3[2];
        if (c >= 2 && r >= 2)
        begin
            idx = (r - 2) * DEF_MAX_OUT_COLUMNS + (c - 2);
            dot = 0;
            for (int i = 0; i < 3; i++)
            begin
                dot += longint'($signed(kern_sh[i][15:0]))  * longint'(win_sh[2*i]);
                dot += longint'($signed(kern_sh[i][31:16])) * longint'(win_sh[2*i+1]);
                dot += longint'($signed(kern_sh[i][47:32])) * longint'(col3[i]);
            end
            acc = p.first_pl ? longint'(bias_sh) * 4096 : psum_sh[idx];
            acc = acc + dot;
            if (acc > SUM_HI) acc = SUM_HI;
            if (acc < SUM_LO) acc = SUM_LO;
            psum_sh[idx] = acc;
            if (p.last_pl)
            begin
                if (acc >= 0)
                    v = (acc + 2048) >>> FRAC_W;
                else
                    v = (acc * LEAK_Q + (64'sd1 <<< 27)) >>> 28;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                a.act   = v[15:0];
                a.ocol  = 6'(c - 2);
                a.orow  = 4'(r - 2);
                a.olast = (c == ncol - 1 && r == nrow - 1);
                act_q.push_back(a);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            win_sh[2*i]   = win_sh[2*i+1];
            win_sh[2*i+1] = col3[i];
        end
        if (c >= ncol - 1)
        begin
            col_pos = 0;
            row_pos = (r >= nrow - 1) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    // sender: bursts of random length separated by random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                conv_pixel('{s_tdata, s_tuser[0], s_tuser[1]});
                n_words++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pix_q.size() > 0)
                begin
                    pix_t p;
                    p = pix_q.pop_front();
                    s_tdata  <= p.smp;
                    s_tuser  <= {p.last_pl, p.first_pl};
                    s_tvalid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stall pattern from a periodically redrawn mode; one long hold on request
    logic hold_req;
    int   hold_cnt;
    int   rx_mode;
    int   rx_cyc;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cnt = 0;
            rx_mode  = 0;
            rx_cyc   = 0;
        end
        else
        begin
            rx_cyc++;
            if (rx_cyc % 64 == 0)
                rx_mode = $urandom_range(0, 2);
            if (hold_req && hold_cnt == 0)
                hold_cnt = HOLD_LEN;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (rx_mode == 0)
                m_tready <= 1'b1;
            else if (rx_mode == 1)
                m_tready <= ($urandom_range(0, 1) == 1);
            else
                m_tready <= ($urandom_range(0, 7) == 0);
        end
    end

    // result check against the oldest expected activation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            act_t got;
            act_t want;
            got = '{m_tdata[15:0], m_tdata[21:16], m_tdata[25:22], m_tlast};
            n_results++;
            if (act_q.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                n_err++;
            end
            else
            begin
                want = act_q.pop_front();
                if (got.act !== want.act)
                    $display("%0t: value exp %h got %h", $time, want.act, got.act);
                if (got.ocol !== want.ocol)
                    $display("%0t: column exp %0d got %0d", $time, want.ocol, got.ocol);
                if (got.orow !== want.orow)
                    $display("%0t: row exp %0d got %0d", $time, want.orow, got.orow);
                if (got.olast !== want.olast)
                    $display("%0t: tlast exp %b got %b", $time, want.olast, got.olast);
                if (got !== want)
                    n_err++;
            end
        end
    end

    // watchdog: cycles without any accepted word
    int stuck;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stuck = 0;
        else
            stuck++;
        if (stuck >= WDOG_MAX)
        begin
            $display("timeout at %0t", $time);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic reg_write(input logic [CIDX_W-1:0] idx, input logic [47:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_KERNEL_TOP: kern_sh[0] = val;
            REG_KERNEL_MID: kern_sh[1] = val;
            REG_KERNEL_BOT: kern_sh[2] = val;
            REG_BIAS:       bias_sh    = val[15:0];
            REG_IN_COLS:    cols_sh    = val[6:0];
            REG_IN_ROWS:    rows_sh    = val[4:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge clk); while (pix_q.size() != 0 || s_tvalid || act_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_layer(input logic [47:0] kt, input logic [47:0] km,
                             input logic [47:0] kb, input logic [47:0] bi,
                             input logic [47:0] nc, input logic [47:0] nr);
        reg_write(REG_KERNEL_TOP, kt);
        reg_write(REG_KERNEL_MID, km);
        reg_write(REG_KERNEL_BOT, kb);
        reg_write(REG_BIAS, bi);
        reg_write(REG_IN_COLS, nc);
        reg_write(REG_IN_ROWS, nr);
    endtask

    function automatic logic [15:0] rnd_sample(input int kind);
        case (kind)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 1023)) - 512);
            2: return ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 16383)) - 8192);
        endcase
    endfunction

    function automatic logic [47:0] rnd_kernel();
        if ($urandom_range(0, 3) == 0)
            return 48'({$urandom(), $urandom()});
        return {16'($signed($urandom_range(0, 4095)) - 2048),
                16'($signed($urandom_range(0, 4095)) - 2048),
                16'($signed($urandom_range(0, 4095)) - 2048)};
    endfunction

    task automatic push_pixels(input int n, input logic fp, input logic lp,
                               input int kind);
        for (int i = 0; i < n; i++)
            pix_q.push_back('{rnd_sample(kind), fp, lp});
    endtask

    function automatic int eff_size(input int v, input int hi);
        return (v < 3) ? 3 : (v > hi) ? hi : v;
    endfunction

    initial
    begin
        int nc;
        int nr;
        int np;
        int plane_px;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_req  = 1'b0;
        n_err     = 0;
        n_words   = 0;
        n_results = 0;
        kern_sh   = '{default: '0};
        bias_sh   = '0;
        cols_sh   = RST_IN_COLS;
        rows_sh   = RST_IN_ROWS;
        line_sh   = '{default: '0};
        win_sh    = '{default: '0};
        psum_sh   = '{default: 0};
        col_pos   = 0;
        row_pos   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // sizes below the minimum clamp to 3x3: one result per plane
        set_layer({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, 16'h7fff, 0, 0);
        for (int i = 0; i < 9; i++) pix_q.push_back('{16'h7fff, 1'b1, 1'b1});
        drain();
        reg_write(REG_BIAS, 16'h8000);
        for (int i = 0; i < 9; i++) pix_q.push_back('{16'h8000, 1'b1, 1'b1});
        drain();
        set_layer({3{16'h8000}}, {3{16'h7fff}}, 48'h0, 48'hffff_ffff_0001, 2, 1);
        for (int i = 0; i < 9; i++) pix_q.push_back('{16'h7fff, 1'b1, 1'b1});
        drain();

        // multi-plane accumulation; ignored register indexes written too
        set_layer(rnd_kernel(), rnd_kernel(), rnd_kernel(), 16'h0123, 5, 4);
        reg_write(3'd6, '1);
        reg_write(3'd7, '1);
        push_pixels(20, 1'b1, 1'b0, 1);
        push_pixels(20, 1'b0, 1'b0, 0);
        push_pixels(20, 1'b0, 1'b1, 3);
        drain();

        // oversized settings clamp to the full tile; four rows while the sink holds off
        set_layer(rnd_kernel(), rnd_kernel(), rnd_kernel(), 16'($urandom()), 127, 31);
        push_pixels(ROW_LEN * 4, 1'b1, 1'b1, 0);
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        drain();
        // rows shortened below the position: one more row closes the plane
        reg_write(REG_IN_ROWS, 3);
        push_pixels(ROW_LEN, 1'b1, 1'b0, 0);
        drain();

        // sizes shortened in the middle of a plane
        set_layer(rnd_kernel(), rnd_kernel(), rnd_kernel(), 16'($urandom()), 10, 6);
        push_pixels(35, 1'b1, 1'b1, 3);
        drain();
        reg_write(REG_IN_COLS, 4);
        reg_write(REG_IN_ROWS, 4);
        push_pixels(17, 1'b1, 1'b1, 3);
        drain();
        set_layer(rnd_kernel(), rnd_kernel(), rnd_kernel(), 16'($urandom()), 8, 5);
        push_pixels(40, 1'b1, 1'b1, 1);
        drain();

        // random layers: mostly small tiles of several planes each
        while (n_words < 760)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                nc = $urandom_range(0, 127);
                nr = $urandom_range(0, 31);
            end
            else
            begin
                nc = $urandom_range(3, 12);
                nr = $urandom_range(3, 7);
            end
            set_layer(rnd_kernel(), rnd_kernel(), rnd_kernel(), 16'($urandom()), nc, nr);
            plane_px = eff_size(nc, ROW_LEN) * eff_size(nr, DEF_MAX_OUT_ROWS + 2);
            if (plane_px > 400)
                plane_px = eff_size(nc, ROW_LEN) * 4;   // partial first plane only
            np = $urandom_range(1, 4);
            for (int p = 0; p < np; p++)
            begin
                if (p > 0 && n_words + pix_q.size() + plane_px > 840)
                    break;
                // a plane not flagged first only follows a complete plane
                push_pixels(plane_px, (p == 0) || ($urandom_range(0, 4) == 0),
                            (p == np - 1) || ($urandom_range(0, 5) == 0),
                            $urandom_range(0, 3));
                if (plane_px != eff_size(nc, ROW_LEN) * eff_size(nr, DEF_MAX_OUT_ROWS + 2))
                    break;
            end
            drain();
            // close a partial plane: shortened rows make the next row the last one
            if (col_pos != 0 || row_pos != 0)
            begin
                reg_write(REG_IN_ROWS, 3);
                push_pixels(eff_size(nc, ROW_LEN) - col_pos, 1'b1, 1'b0, 0);
                drain();
            end
        end

        $display("covered %0d input words and %0d activations, clamped and shortened sizes",
                 n_words, n_results);
        $display("stimulus included saturating extremes and one long sink hold-off");
        if (n_err == 0 && act_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
